// File: src/tcg_pkg.sv
`default_nettype none

package tcg_pkg;

  // Font geometry
  localparam int FONT_GLYPHS = 128;
  localparam int GLYPH_W     = $clog2(FONT_GLYPHS);
  localparam int FONT_DEPTH  = FONT_GLYPHS * 8;
  localparam int FONT_AW     = GLYPH_W + 3;

  // Field widths
  localparam int CFG_W      = 13;
  localparam int CFG_AW     = 2;
  localparam int COORD_W    = 14;
  localparam int WORK_W     = 15;
  localparam int OFFSET_W   = 26;
  localparam int COLOR_W    = 24;
  localparam int OP_W       = 2;
  localparam int CODE_W     = 8;
  localparam int ROW_W      = 3;
  localparam int BITS_W     = 8;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 56;

  // Operations
  localparam logic [OP_W-1:0] OP_PUT  = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD = 2'd1;
  localparam logic [OP_W-1:0] OP_HOME = 2'd2;

  // Register indexes
  localparam logic [CFG_AW-1:0] REG_SCREEN_WIDTH  = 2'd0;
  localparam logic [CFG_AW-1:0] REG_SCREEN_HEIGHT = 2'd1;
  localparam logic [CFG_AW-1:0] REG_LINE_STRIDE   = 2'd2;

  // Control characters
  localparam logic [CODE_W-1:0] CH_BACKSPACE = 8'd8;
  localparam logic [CODE_W-1:0] CH_NEWLINE   = 8'd10;
  localparam logic [CODE_W-1:0] CH_RETURN    = 8'd13;

  // Cursor movement
  localparam logic [COORD_W-1:0] HOME_POS     = 14'd10;
  localparam logic [COORD_W-1:0] ADVANCE      = 14'd9;
  localparam logic [WORK_W-1:0]  CELL         = 15'd8;
  localparam logic [WORK_W-1:0]  LINE_ADVANCE = 15'd12;

  localparam logic [COLOR_W-1:0] COLOR_GLYPH = 24'hFFFFFF;
  localparam logic [COLOR_W-1:0] COLOR_ERASE = 24'h1B1B1B;

  localparam logic [CFG_W-1:0] RESET_WIDTH  = 13'd640;
  localparam logic [CFG_W-1:0] RESET_HEIGHT = 13'd480;
  localparam logic [CFG_W-1:0] RESET_STRIDE = 13'd640;

  typedef struct packed {
    logic [CFG_W-1:0] width;
    logic [CFG_W-1:0] height;
    logic [CFG_W-1:0] stride;
  } tcg_geom_t;

  typedef struct packed {
    logic               start;
    logic               erase;
    logic [GLYPH_W-1:0] glyph;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
  } tcg_job_t;

  typedef struct packed {
    logic               rd_en;
    logic [FONT_AW-1:0] rd_addr;
  } tcg_font_rd_t;

endpackage

`default_nettype wire

// File: src/tcg_font_ram.sv
`default_nettype none

module tcg_font_ram (
  input  wire                         clk,
  input  wire                         wr_en,
  input  wire  [tcg_pkg::FONT_AW-1:0] wr_addr,
  input  wire  [tcg_pkg::BITS_W-1:0]  wr_data,
  input  tcg_pkg::tcg_font_rd_t       rd,
  output logic [tcg_pkg::BITS_W-1:0]  rd_data
);
  import tcg_pkg::*;

  logic [BITS_W-1:0] mem [FONT_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.rd_en) begin
      rd_data <= mem[rd.rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: src/tcg_raster.sv
`default_nettype none

module tcg_raster (
  input  wire                            clk,
  input  wire                            rst_n,
  input  tcg_pkg::tcg_job_t              job,
  input  tcg_pkg::tcg_geom_t             geom,
  input  wire  [tcg_pkg::BITS_W-1:0]     font_q,
  output tcg_pkg::tcg_font_rd_t          font_rd,
  output logic                           done,
  output logic                           out_tvalid,
  input  wire                            out_tready,
  output logic [tcg_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                           out_tlast
);
  import tcg_pkg::*;

  localparam int PROD_W = COORD_W + CFG_W;

  localparam logic [1:0] R_IDLE  = 2'd0;
  localparam logic [1:0] R_BASE  = 2'd1;
  localparam logic [1:0] R_DRAW  = 2'd2;
  localparam logic [1:0] R_FLUSH = 2'd3;

  logic [1:0]          rstate_r, rstate_nxt;
  logic                erase_r;
  logic [GLYPH_W-1:0]  glyph_r;
  logic [COORD_W-1:0]  col_r, row_r;
  logic [ROW_W-1:0]    i_r, j_r;
  logic [OFFSET_W-1:0] base_r;
  logic                pend_valid_r;
  logic [OFFSET_W-1:0] pend_off_r;
  logic                out_valid_r;
  logic [OFFSET_W-1:0] out_off_r;
  logic [COLOR_W-1:0]  out_color_r;
  logic                out_last_r;

  logic [WORK_W-1:0]   x, y;
  logic [PROD_W-1:0]   prod;
  logic [OFFSET_W-1:0] offset;
  logic                hit, out_free, stall, adv, flush_go;

  assign x        = WORK_W'(col_r) + WORK_W'(j_r);
  assign y        = WORK_W'(row_r) + WORK_W'(i_r);
  assign prod     = PROD_W'(row_r) * PROD_W'(geom.stride);
  assign offset   = base_r + OFFSET_W'(x);
  assign hit      = (erase_r | font_q[j_r]) && (x < WORK_W'(geom.width))
                    && (y < WORK_W'(geom.height));
  assign out_free = !out_valid_r || out_tready;
  assign stall    = hit && pend_valid_r && !out_free;
  assign adv      = (rstate_r == R_DRAW) && !stall;
  assign flush_go = (rstate_r == R_FLUSH) && (!pend_valid_r || out_free);
  assign done     = flush_go;

  always_comb begin
    font_rd.rd_en   = 1'b0;
    font_rd.rd_addr = {glyph_r, ROW_W'(0)};
    if (rstate_r == R_BASE) begin
      font_rd.rd_en = 1'b1;
    end else if (adv && (j_r == ROW_W'(7))) begin
      font_rd.rd_en   = 1'b1;
      font_rd.rd_addr = {glyph_r, i_r + ROW_W'(1)};
    end
  end

  always_comb begin
    rstate_nxt = rstate_r;
    case (rstate_r)
      R_IDLE: begin
        if (job.start) rstate_nxt = R_BASE;
      end
      R_BASE: begin
        rstate_nxt = R_DRAW;
      end
      R_DRAW: begin
        if (adv && (j_r == ROW_W'(7)) && (i_r == ROW_W'(7))) rstate_nxt = R_FLUSH;
      end
      R_FLUSH: begin
        if (flush_go) rstate_nxt = R_IDLE;
      end
      default: rstate_nxt = R_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rstate_r     <= R_IDLE;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      rstate_r <= rstate_nxt;
      if (adv && hit) begin
        pend_valid_r <= 1'b1;
      end else if (flush_go) begin
        pend_valid_r <= 1'b0;
      end
      if ((adv && hit && pend_valid_r) || (flush_go && pend_valid_r)) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((rstate_r == R_IDLE) && job.start) begin
      erase_r <= job.erase;
      glyph_r <= job.glyph;
      col_r   <= job.col;
      row_r   <= job.row;
    end
    if (rstate_r == R_BASE) begin
      base_r <= prod[OFFSET_W-1:0];
      i_r    <= '0;
      j_r    <= '0;
    end else if (adv) begin
      j_r <= j_r + ROW_W'(1);
      if (j_r == ROW_W'(7)) begin
        i_r    <= i_r + ROW_W'(1);
        base_r <= base_r + OFFSET_W'(geom.stride);
      end
    end
    if (adv && hit) begin
      pend_off_r <= offset;
    end
    // move the held pixel out; it is last only when the scan is over
    if ((adv && hit && pend_valid_r) || (flush_go && pend_valid_r)) begin
      out_off_r   <= pend_off_r;
      out_color_r <= erase_r ? COLOR_ERASE : COLOR_GLYPH;
      out_last_r  <= flush_go;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_DATA_W - COLOR_W - OFFSET_W)'(0), out_color_r, out_off_r};
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

// File: src/text_console_glyph_renderer.sv
`default_nettype none

// Text console glyph renderer. Each input item is a command: put a character
// (tuser 0), load one 8-bit row of the 8x8 font (tuser 1) or home the cursor
// (tuser 2). A printable character produces one output item per lit glyph pixel,
// white, and a backspace paints the cell it steps back into dark grey; each
// output item carries the framebuffer offset y*line_stride+x and the colour,
// with tlast on the final pixel of the character. Pixels off the visible
// screen are dropped, and a character that lights no pixel yields no output.
// Codes at or above the font size draw nothing but still advance the cursor.
// Font rows are undefined until loaded. Font loads, home and unused commands
// are handled in the idle state; newline, carriage return and characters with
// no glyph pass through the cursor update. A drawing character walks its 8x8
// cell one pixel per cycle through the font memory's registered read port,
// held while out_tready holds back the output: a base multiply, the scan, a
// flush and a cursor update. The next item is taken once the cursor update is
// done. Configuration registers may be written only while the block is idle.

module text_console_glyph_renderer (
  input  wire                            clk,
  input  wire                            rst_n,
  // in_tdata: char_code[7:0], glyph_row[10:8], row_bits[18:11], zero fill
  input  wire                            in_tvalid,
  output logic                           in_tready,
  input  wire  [tcg_pkg::IN_DATA_W-1:0]  in_tdata,
  // in_tuser: op[1:0]
  input  wire  [tcg_pkg::OP_W-1:0]       in_tuser,
  // out_tdata: pixel_offset[25:0], pixel_color[49:26], zero fill
  output logic                           out_tvalid,
  input  wire                            out_tready,
  output logic [tcg_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                           out_tlast,
  input  wire                            cfg_wr_en,
  input  wire  [tcg_pkg::CFG_AW-1:0]     cfg_addr,
  input  wire  [tcg_pkg::CFG_W-1:0]      cfg_wdata
);
  import tcg_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DRAW = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0]         state_r, state_nxt;
  tcg_geom_t          geom_r;
  logic [COORD_W-1:0] cur_col_r, cur_row_r;
  logic [WORK_W-1:0]  work_col_r, work_row_r;
  logic [WORK_W-1:0]  work_col_nxt, work_row_nxt;

  logic [OP_W-1:0]    op;
  logic [CODE_W-1:0]  code;
  logic [ROW_W-1:0]   glyph_row;
  logic [BITS_W-1:0]  row_bits;
  logic               in_acc, code_ok, draw;
  tcg_job_t           job;
  tcg_font_rd_t       font_rd;
  logic [BITS_W-1:0]  font_q;
  logic               raster_done;

  // cursor update terms for the end of a character
  logic               wrap_c, home_c;
  logic [WORK_W-1:0]  row_wrapped;

  assign op        = in_tuser;
  assign code      = in_tdata[CODE_W-1:0];
  assign glyph_row = in_tdata[CODE_W +: ROW_W];
  assign row_bits  = in_tdata[CODE_W+ROW_W +: BITS_W];
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign code_ok   = (CODE_W+1)'(code) < (CODE_W+1)'(FONT_GLYPHS);

  // Decode a put: the working cursor before the edge checks, and what to draw
  always_comb begin
    work_col_nxt = WORK_W'(cur_col_r);
    work_row_nxt = WORK_W'(cur_row_r);
    draw         = 1'b0;
    job.erase    = 1'b0;
    job.glyph    = code[GLYPH_W-1:0];
    job.col      = cur_col_r;
    job.row      = cur_row_r;
    case (code)
      CH_NEWLINE: begin
        work_col_nxt = WORK_W'(HOME_POS);
        work_row_nxt = WORK_W'(cur_row_r) + LINE_ADVANCE;
      end
      CH_RETURN: begin
        work_col_nxt = WORK_W'(HOME_POS);
      end
      CH_BACKSPACE: begin
        // step back a cell and blank it, unless the column is below ADVANCE
        if (cur_col_r >= ADVANCE) begin
          work_col_nxt = WORK_W'(cur_col_r - ADVANCE);
          job.col      = cur_col_r - ADVANCE;
          job.erase    = 1'b1;
          draw         = 1'b1;
        end
      end
      default: begin
        work_col_nxt = WORK_W'(cur_col_r) + WORK_W'(ADVANCE);
        draw         = code_ok;
      end
    endcase
    job.start = in_acc && (op == OP_PUT) && draw;
  end

  // Wrap at the right edge, then home at the bottom; both row outcomes are
  // compared in parallel
  assign wrap_c      = (work_col_r + CELL) >= WORK_W'(geom_r.width);
  assign row_wrapped = work_row_r + LINE_ADVANCE;
  assign home_c      = wrap_c ? ((row_wrapped + CELL) >= WORK_W'(geom_r.height))
                              : ((work_row_r + CELL) >= WORK_W'(geom_r.height));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && (op == OP_PUT)) state_nxt = draw ? ST_DRAW : ST_FIN;
      end
      ST_DRAW: begin
        if (raster_done) state_nxt = ST_FIN;
      end
      ST_FIN: begin
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      geom_r.width  <= RESET_WIDTH;
      geom_r.height <= RESET_HEIGHT;
      geom_r.stride <= RESET_STRIDE;
      cur_col_r     <= HOME_POS;
      cur_row_r     <= HOME_POS;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        case (cfg_addr)
          REG_SCREEN_WIDTH:  geom_r.width  <= cfg_wdata;
          REG_SCREEN_HEIGHT: geom_r.height <= cfg_wdata;
          REG_LINE_STRIDE:   geom_r.stride <= cfg_wdata;
          default: ;
        endcase
      end
      if (in_acc && (op == OP_HOME)) begin
        cur_col_r <= HOME_POS;
        cur_row_r <= HOME_POS;
      end
      if (state_r == ST_FIN) begin
        if (home_c) begin
          cur_col_r <= HOME_POS;
          cur_row_r <= HOME_POS;
        end else if (wrap_c) begin
          cur_col_r <= HOME_POS;
          cur_row_r <= row_wrapped[COORD_W-1:0];
        end else begin
          cur_col_r <= work_col_r[COORD_W-1:0];
          cur_row_r <= work_row_r[COORD_W-1:0];
        end
      end
    end
  end

  // hold the working cursor until the edge checks at the end of the item
  always_ff @(posedge clk) begin
    if (in_acc && (op == OP_PUT)) begin
      work_col_r <= work_col_nxt;
      work_row_r <= work_row_nxt;
    end
  end

  tcg_font_ram u_font (
    .clk     (clk),
    .wr_en   (in_acc && (op == OP_LOAD) && code_ok),
    .wr_addr ({code[GLYPH_W-1:0], glyph_row}),
    .wr_data (row_bits),
    .rd      (font_rd),
    .rd_data (font_q)
  );

  tcg_raster u_raster (
    .clk        (clk),
    .rst_n      (rst_n),
    .job        (job),
    .geom       (geom_r),
    .font_q     (font_q),
    .font_rd    (font_rd),
    .done       (raster_done),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

// File: src/tcg_checker.sv
`default_nettype none

module tcg_checker (
  input wire                            clk,
  input wire                            rst_n,
  input wire                            in_tvalid,
  input wire                            in_tready,
  input wire [tcg_pkg::OP_W-1:0]        in_tuser,
  input wire                            out_tvalid,
  input wire                            out_tready,
  input wire [tcg_pkg::OUT_DATA_W-1:0]  out_tdata,
  input wire                            out_tlast
);
  import tcg_pkg::*;

  // a stalled output item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled output item changed");

  a_color: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[OFFSET_W +: COLOR_W] == COLOR_GLYPH)
                || (out_tdata[OFFSET_W +: COLOR_W] == COLOR_ERASE))
    else $error("pixel colour is neither glyph nor erase");

  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // commands other than put leave the input open
  a_quick_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser != OP_PUT) |=> in_tready)
    else $error("non-drawing command blocked the input");

  // more pixels of the same character follow a non-final one
  a_busy_mid_char: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> !in_tready)
    else $error("input opened in the middle of a character");

endmodule

bind text_console_glyph_renderer tcg_checker u_tcg_checker (.*);

`default_nettype wire

// File: tb/glyph_pixel_checker.sv
module glyph_pixel_checker
  import tcg_pkg::*;
(
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_tvalid,
  input  wire                  in_tready,
  // in_tdata: char_code[7:0], glyph_row[10:8], row_bits[18:11], zero fill
  input  wire [IN_DATA_W-1:0]  in_tdata,
  // in_tuser: op[1:0]
  input  wire [OP_W-1:0]       in_tuser,
  input  wire                  out_tvalid,
  input  wire                  out_tready,
  // out_tdata: pixel_offset[25:0], pixel_color[49:26], zero fill
  input  wire [OUT_DATA_W-1:0] out_tdata,
  input  wire                  out_tlast,
  input  wire                  cfg_wr_en,
  input  wire [CFG_AW-1:0]     cfg_addr,
  input  wire [CFG_W-1:0]      cfg_wdata,
  output int                   pending,
  output int                   mismatches
);

  typedef struct packed {
    logic [OFFSET_W-1:0] offset;
    logic [COLOR_W-1:0]  color;
    logic                last;
  } pixel_t;

  localparam int unsigned COORD_MASK = (1 << COORD_W) - 1;

  pixel_t            pixels_due[$];
  pixel_t            char_px[$];
  logic [BITS_W-1:0] font_rows [FONT_DEPTH];
  int unsigned       scr_w, scr_h, stride;
  int unsigned       cur_col, cur_row;

  // Queue one pixel write of the current character, unless it falls off screen.
  function automatic void plot(int unsigned x, int unsigned y, logic [COLOR_W-1:0] color);
    pixel_t      px;
    logic [63:0] off;
    if (x >= scr_w || y >= scr_h) return;
    off       = 64'(y) * 64'(stride) + 64'(x);
    px.offset = off[OFFSET_W-1:0];
    px.color  = color;
    px.last   = 1'b0;
    char_px.push_back(px);
  endfunction

  task automatic render(input logic [OP_W-1:0] op, input logic [CODE_W-1:0] code,
                        input logic [ROW_W-1:0] grow, input logic [BITS_W-1:0] bits);
    logic [BITS_W-1:0] r;
    pixel_t            px;
    int                i, j;
    char_px.delete();
    if (op == OP_LOAD) begin
      if (code < FONT_GLYPHS) font_rows[int'(code) * 8 + int'(grow)] = bits;
    end else if (op == OP_HOME) begin
      cur_col = HOME_POS;
      cur_row = HOME_POS;
    end else if (op == OP_PUT) begin
      if (code == CH_NEWLINE) begin
        cur_col = HOME_POS;
        cur_row = cur_row + LINE_ADVANCE;
      end else if (code == CH_RETURN) begin
        cur_col = HOME_POS;
      end else if (code == CH_BACKSPACE) begin
        if (cur_col >= ADVANCE) begin
          cur_col = cur_col - ADVANCE;
          for (i = 0; i < CELL; i++)
            for (j = 0; j < CELL; j++)
              plot(cur_col + j, cur_row + i, COLOR_ERASE);
        end
      end else begin
        for (i = 0; i < CELL; i++) begin
          r = (code < FONT_GLYPHS) ? font_rows[int'(code) * 8 + i] : '0;
          for (j = 0; j < CELL; j++)
            if (r[j]) plot(cur_col + j, cur_row + i, COLOR_GLYPH);
        end
        cur_col = cur_col + ADVANCE;
      end
      // wrap at the right edge, then home at the bottom
      if (cur_col + CELL >= scr_w) begin
        cur_col = HOME_POS;
        cur_row = cur_row + LINE_ADVANCE;
      end
      if (cur_row + CELL >= scr_h) begin
        cur_col = HOME_POS;
        cur_row = HOME_POS;
      end
      cur_col = cur_col & COORD_MASK;
      cur_row = cur_row & COORD_MASK;
    end
    if (char_px.size() > 0) begin
      px      = char_px.pop_back();
      px.last = 1'b1;
      char_px.push_back(px);
    end
    foreach (char_px[k]) pixels_due.push_back(char_px[k]);
  endtask

  always @(posedge clk) begin
    pixel_t want;
    int     bad;
    bad = 0;
    if (!rst_n) begin
      scr_w   = RESET_WIDTH;
      scr_h   = RESET_HEIGHT;
      stride  = RESET_STRIDE;
      cur_col = HOME_POS;
      cur_row = HOME_POS;
      pixels_due.delete();
      mismatches <= 0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_addr)
          REG_SCREEN_WIDTH:  scr_w  = cfg_wdata;
          REG_SCREEN_HEIGHT: scr_h  = cfg_wdata;
          REG_LINE_STRIDE:   stride = cfg_wdata;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready)
        render(in_tuser, in_tdata[CODE_W-1:0], in_tdata[CODE_W+ROW_W-1:CODE_W],
               in_tdata[CODE_W+ROW_W+BITS_W-1:CODE_W+ROW_W]);
      if (out_tvalid && out_tready) begin
        if (pixels_due.size() == 0) begin
          $error("pixel item with none due: pixel_offset %0d pixel_color %h last %b",
                 out_tdata[OFFSET_W-1:0], out_tdata[OFFSET_W+COLOR_W-1:OFFSET_W], out_tlast);
          bad++;
        end else begin
          want = pixels_due.pop_front();
          if (out_tdata[OFFSET_W-1:0] !== want.offset) begin
            $error("pixel_offset: expected %0d, actual %0d",
                   want.offset, out_tdata[OFFSET_W-1:0]);
            bad++;
          end
          if (out_tdata[OFFSET_W+COLOR_W-1:OFFSET_W] !== want.color) begin
            $error("pixel_color: expected %h, actual %h",
                   want.color, out_tdata[OFFSET_W+COLOR_W-1:OFFSET_W]);
            bad++;
          end
          if (out_tlast !== want.last) begin
            $error("last: expected %b, actual %b", want.last, out_tlast);
            bad++;
          end
        end
      end
      mismatches <= mismatches + bad;
    end
    pending <= pixels_due.size();
  end

endmodule

// File: tb/testbench.sv
module testbench;
  import tcg_pkg::*;

  // op 3 has no meaning; the block must swallow it
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  localparam int LIMIT_CYCLES  = 1_500_000;
  // allow for a drawing character that lights nothing
  localparam int SETTLE_CYCLES = 100;
  // long enough for the block to fill up and stall its input
  localparam int LONG_HOLD     = 600;

  // glyph rows that cover every bit position, full, empty and both edges
  localparam logic [BITS_W-1:0] EDGE_ROWS [8] =
    '{8'hFF, 8'h01, 8'h80, 8'h00, 8'hAA, 8'h55, 8'h81, 8'hFF};

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [OP_W-1:0]       in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;
  logic                  cfg_wr_en;
  logic [CFG_AW-1:0]     cfg_addr;
  logic [CFG_W-1:0]      cfg_wdata;

  int pending;
  int mismatches;
  int cycle_count = 0;
  int useful      = 0;   // items the block acts upon
  bit quiet          = 1'b0;
  bit long_hold_req  = 1'b0;
  bit long_hold_done = 1'b0;

  // which rows of each glyph hold defined data; a glyph is drawn only once full
  logic [7:0]        rows_loaded [FONT_GLYPHS];
  logic [CODE_W-1:0] ready_glyphs[$];

  text_console_glyph_renderer DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  glyph_pixel_checker glyph_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .pending    (pending),
    .mismatches (mismatches)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Watchdog: give up well beyond the slowest legal run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("FAIL text_console_glyph_renderer");
      $finish;
    end
  end

  // Offer one item and hold it until the block takes it. Insert a random gap
  // first, unless the run is in its quiet tail. Keep tvalid high between
  // back-to-back items so it is never dropped and raised in one step.
  task automatic send_item(input logic [OP_W-1:0] op, input logic [CODE_W-1:0] code,
                           input logic [ROW_W-1:0] grow, input logic [BITS_W-1:0] bits);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 12);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {{(IN_DATA_W-CODE_W-ROW_W-BITS_W){1'b0}}, bits, grow, code};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (op != OP_UNUSED && !(op == OP_LOAD && code >= FONT_GLYPHS)) useful++;
  endtask

  function automatic logic [BITS_W-1:0] random_row();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      default: return BITS_W'($urandom_range(0, 255));
    endcase
  endfunction

  // Load one font row and note when a glyph becomes fully defined.
  task automatic load_row(input logic [CODE_W-1:0] code, input logic [ROW_W-1:0] grow,
                          input logic [BITS_W-1:0] bits);
    bit was_full;
    send_item(OP_LOAD, code, grow, bits);
    if (code < FONT_GLYPHS) begin
      was_full = &rows_loaded[code];
      rows_loaded[code][grow] = 1'b1;
      if (!was_full && &rows_loaded[code]) ready_glyphs.push_back(code);
    end
  endtask

  // Put a character; load any missing rows of its glyph beforehand so that
  // no undefined font row is ever drawn.
  task automatic put_char(input logic [CODE_W-1:0] code);
    int g;
    if (code < FONT_GLYPHS && code != CH_BACKSPACE && code != CH_NEWLINE &&
        code != CH_RETURN)
      for (g = 0; g < 8; g++)
        if (!rows_loaded[code][g]) load_row(code, ROW_W'(g), random_row());
    send_item(OP_PUT, code, ROW_W'($urandom_range(0, 7)), BITS_W'($urandom_range(0, 255)));
  endtask

  // Mostly drawing traffic over loaded glyphs, with cursor moves, reloads,
  // out-of-range loads and dead opcodes mixed in.
  task automatic random_item();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 40 && ready_glyphs.size() > 0)
      put_char(ready_glyphs[$urandom_range(0, ready_glyphs.size() - 1)]);
    else if (sel < 55) put_char(CODE_W'($urandom_range(0, FONT_GLYPHS - 1)));
    else if (sel < 62) put_char(CODE_W'($urandom_range(FONT_GLYPHS, 255)));
    else if (sel < 70) put_char(CH_NEWLINE);
    else if (sel < 74) put_char(CH_RETURN);
    else if (sel < 82) put_char(CH_BACKSPACE);
    else if (sel < 92)
      load_row(CODE_W'($urandom_range(0, 255)), ROW_W'($urandom_range(0, 7)), random_row());
    else if (sel < 96)
      send_item(OP_HOME, CODE_W'($urandom_range(0, 255)), ROW_W'($urandom_range(0, 7)),
                BITS_W'($urandom_range(0, 255)));
    else
      send_item(OP_UNUSED, CODE_W'($urandom_range(0, 255)), ROW_W'($urandom_range(0, 7)),
                BITS_W'($urandom_range(0, 255)));
  endtask

  // Drop tvalid, wait for every expected pixel, then give the block time to
  // finish a character that lit nothing.
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_screen(input int unsigned w, input int unsigned h, input int unsigned s);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= REG_SCREEN_WIDTH;
    cfg_wdata <= CFG_W'(w);
    @(posedge clk);
    cfg_addr  <= REG_SCREEN_HEIGHT;
    cfg_wdata <= CFG_W'(h);
    @(posedge clk);
    cfg_addr  <= REG_LINE_STRIDE;
    cfg_wdata <= CFG_W'(s);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // One phase: reach idle, reprogram the screen, then run random traffic.
  task automatic run_phase(input int unsigned w, input int unsigned h, input int unsigned s,
                           input int count);
    int target;
    settle();
    set_screen(w, h, s);
    target = useful + count;
    while (useful < target) random_item();
  endtask

  // Receiver: bursts of back-pressure, one long hold-off to fill the block,
  // and a free-running ready in the quiet tail.
  initial begin : receiver
    int burst;
    out_tready <= 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (long_hold_req && !long_hold_done) begin
        long_hold_done = 1'b1;
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 9) < 3) begin
        burst = $urandom_range(1, 12);
        out_tready <= 1'b0;
        repeat (burst) @(posedge clk);
      end else begin
        burst = $urandom_range(1, 30);
        out_tready <= 1'b1;
        repeat (burst) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    int g;
    for (g = 0; g < FONT_GLYPHS; g++) rows_loaded[g] = '0;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= OP_PUT;
    cfg_wr_en <= 1'b0;
    cfg_addr  <= REG_SCREEN_WIDTH;
    cfg_wdata <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at the reset geometry.
    // Fill the top glyph with rows covering every bit, full and empty.
    for (g = 0; g < 8; g++) load_row(CODE_W'(FONT_GLYPHS - 1), ROW_W'(g), EDGE_ROWS[g]);
    load_row(8'd0, 3'd0, 8'h00);        // lowest glyph index
    load_row(8'd255, 3'd7, 8'hFF);      // beyond the font: dropped
    put_char(CODE_W'(FONT_GLYPHS - 1)); // draw at home
    put_char(CH_BACKSPACE);             // step back and erase that cell
    put_char(CH_BACKSPACE);             // column 10 -> 1, erase at the left edge
    put_char(CH_BACKSPACE);             // column below 9: nothing moves or draws
    put_char(CH_RETURN);
    put_char(CH_NEWLINE);
    put_char(8'd128);                   // codes without a glyph advance blank
    put_char(8'd255);
    put_char(CODE_W'(FONT_GLYPHS - 1));
    send_item(OP_HOME, 8'd0, 3'd0, 8'd0);
    send_item(OP_UNUSED, 8'd255, 3'd7, 8'hFF);
    put_char(CODE_W'(FONT_GLYPHS - 1));

    // Random part over a spread of geometries, the extremes among them.
    // Ask for the long hold-off on the big screen, where every pixel lands.
    long_hold_req = 1'b1;
    run_phase(8191, 8191, 8191, 35);
    run_phase(1, 1, 1, 10);             // everything clipped, cursor pinned home
    run_phase(15, 15, 8191, 25);        // cell cut at right and bottom edges
    run_phase(100, 60, 100, 30);
    run_phase($urandom_range(9, 400), $urandom_range(9, 300), $urandom_range(1, 8191), 30);
    run_phase(8191, 40, 1, 25);
    // Quiet tail: no idling on either side.
    settle();
    quiet = 1'b1;
    set_screen(RESET_WIDTH, RESET_HEIGHT, RESET_STRIDE);
    g = useful + 45;
    while (useful < g) random_item();
    settle();

    if (mismatches == 0 && pending == 0)
      $display("PASS text_console_glyph_renderer");
    else
      $display("FAIL text_console_glyph_renderer");
    $finish;
  end

endmodule
